// ----- rtl/core/agtg_pkg.sv -----
package agtg_pkg;

  localparam int unsigned RING_SIDES = 6;
  localparam int unsigned TRI_COUNT  = 30;
  localparam int unsigned N_CAP      = 8;
  localparam int unsigned N_SIDE     = 12;
  localparam int unsigned N_HBASE    = 4;
  localparam int unsigned VTX_COUNT  = 3 * RING_SIDES + 1;
  localparam int unsigned VTX_W      = $clog2(VTX_COUNT);
  localparam int unsigned TRI_W      = $clog2(TRI_COUNT);
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned DIV_STEPS  = 31;

  localparam logic [VTX_W-1:0] VB_BASE  = VTX_W'(0);
  localparam logic [VTX_W-1:0] VM_BASE  = VTX_W'(RING_SIDES);
  localparam logic [VTX_W-1:0] VH_BASE  = VTX_W'(2 * RING_SIDES);
  localparam logic [VTX_W-1:0] APEX_IDX = VTX_W'(3 * RING_SIDES);

  localparam logic [30:0] SIN60 = 31'd929887697;

  localparam logic [30:0] TAIL_LENGTH_RST = 31'd65536;
  localparam logic [30:0] HEAD_LENGTH_RST = 31'd32768;
  localparam logic [30:0] TAIL_RADIUS_RST = 31'd6554;
  localparam logic [30:0] HEAD_RADIUS_RST = 31'd13107;

  typedef enum logic [1:0] {
    REG_TAIL_LENGTH = 2'd0,
    REG_HEAD_LENGTH = 2'd1,
    REG_TAIL_RADIUS = 2'd2,
    REG_HEAD_RADIUS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] vector_x;
    logic signed [31:0] vector_y;
    logic signed [31:0] vector_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] corner_a_x;
    logic signed [31:0] corner_a_y;
    logic signed [31:0] corner_a_z;
    logic signed [31:0] corner_b_x;
    logic signed [31:0] corner_b_y;
    logic signed [31:0] corner_b_z;
    logic signed [31:0] corner_c_x;
    logic signed [31:0] corner_c_y;
    logic signed [31:0] corner_c_z;
    logic               last_triangle;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    logic [30:0] tail_length;
    logic [30:0] head_length;
    logic [30:0] tail_radius;
    logic [30:0] head_radius;
  } cfg_t;

  // Element 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][31:0] vec3_t;

  // Vertices 0..5 are the tail base ring, 6..11 the tail top ring,
  // 12..17 the head base ring and 18 the apex.
  typedef struct packed {
    vec3_t [VTX_COUNT-1:0] vtx;
    logic                  deg;
  } vset_t;

  typedef struct packed {
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [VTX_W-1:0] c;
  } tri_sel_t;

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
    return (x + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  // Picks the three vertices of triangle k of a glyph.
  function automatic tri_sel_t tri_select(input logic [TRI_W-1:0] k);
    tri_sel_t         s;
    logic [TRI_W-1:0] t;
    logic [VTX_W-1:0] i;
    logic [VTX_W-1:0] n;
    logic [VTX_W-1:0] base;
    s    = '0;
    t    = '0;
    base = VB_BASE;
    if (k < TRI_W'(N_CAP)) begin
      i    = VTX_W'(k[2:1]) + VTX_W'(1);
      base = k[0] ? VM_BASE : VB_BASE;
      s.a  = base;
      s.b  = base + i;
      s.c  = base + i + VTX_W'(1);
    end else if (k < TRI_W'(N_CAP + N_SIDE)) begin
      t = k - TRI_W'(N_CAP);
      i = VTX_W'(t[TRI_W-1:1]);
      n = (i == VTX_W'(RING_SIDES - 1)) ? VTX_W'(0) : i + VTX_W'(1);
      if (!t[0]) begin
        s.a = VB_BASE + i;
        s.b = VB_BASE + n;
        s.c = VM_BASE + i;
      end else begin
        s.a = VB_BASE + n;
        s.b = VM_BASE + n;
        s.c = VM_BASE + i;
      end
    end else if (k < TRI_W'(N_CAP + N_SIDE + N_HBASE)) begin
      i   = VTX_W'(k - TRI_W'(N_CAP + N_SIDE)) + VTX_W'(1);
      s.a = VH_BASE;
      s.b = VH_BASE + i;
      s.c = VH_BASE + i + VTX_W'(1);
    end else begin
      i   = VTX_W'(k - TRI_W'(N_CAP + N_SIDE + N_HBASE));
      n   = (i == VTX_W'(RING_SIDES - 1)) ? VTX_W'(0) : i + VTX_W'(1);
      s.a = VH_BASE + i;
      s.b = VH_BASE + n;
      s.c = APEX_IDX;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/agtg_front.sv -----
module agtg_front import agtg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  cfg_t     cfg_i,
  output logic     push_o,
  output vset_t    push_data_o,
  input  logic     q_full_i
);

  typedef enum logic [11:0] {
    F_IDLE   = 12'h001,
    F_SHIFT  = 12'h002,
    F_SQ     = 12'h004,
    F_SUM    = 12'h008,
    F_SQRT   = 12'h010,
    F_DIVSET = 12'h020,
    F_DIV    = 12'h040,
    F_PROD   = 12'h080,
    F_BASIS  = 12'h100,
    F_WS     = 12'h200,
    F_RING   = 12'h400,
    F_PUSH   = 12'h800
  } fstate_e;

  fstate_e state_q, state_d;
  logic    buf_valid_q, buf_valid_d;
  in_item_t buf_q;

  vec3_t              p_q, v_q;
  logic [31:0]        mag_q [5];
  logic [63:0]        sq_q  [5];
  logic [63:0]        rad_q [2];
  logic [63:0]        res_q [2];
  logic [63:0]        bit_q;
  logic [31:0]        rem_q [5];
  logic [30:0]        nlo_q [5];
  logic [30:0]        quo_q [5];
  logic [4:0]         cnt_q;
  logic signed [63:0] pw_q  [4];
  logic signed [63:0] ltp_q [3];
  logic [63:0]        app_q [3];
  logic signed [33:0] w_q   [3];
  logic signed [33:0] ltl_q [3];
  logic signed [63:0] ws_q  [3];
  logic signed [33:0] d_q   [3];
  logic signed [63:0] trp_q [3];
  logic signed [63:0] hrp_q [3];
  logic [2:0]         ring_q;
  logic [1:0]         ph_q;
  vset_t              vset_q;

  logic               deg_in, take, done_l, done_u;
  logic [63:0]        sq_trial [2];
  logic               sq_ge    [2];
  logic [31:0]        div_len  [5];
  logic [32:0]        div_t    [5];
  logic               div_ge   [5];
  logic signed [31:0] lv_c [3];
  logic signed [31:0] u_c  [3];
  logic [31:0]        span;
  logic signed [63:0] ring_sum [3];
  logic signed [63:0] u64, apex64, tr64, hr64, p64, ltl64;
  logic [63:0]        apq;
  vec3_t              apex_c, vb_c, vm_c, vh_c;

  assign deg_in = (buf_q.vector_x == '0) && (buf_q.vector_z == '0);
  assign take   = (state_q == F_IDLE) && buf_valid_q;
  assign done_l = |{mag_q[0][31:30], mag_q[1][31:30], mag_q[2][31:30]};
  assign done_u = |{mag_q[3][31:30], mag_q[4][31:30]};
  assign span   = {1'b0, cfg_i.tail_length} + {1'b0, cfg_i.head_length};

  assign in_stall_o  = buf_valid_q;
  assign push_o      = (state_q == F_PUSH) && !q_full_i;
  assign push_data_o = vset_q;

  always_comb begin
    buf_valid_d = buf_valid_q;
    if (in_valid_i && !buf_valid_q) begin
      buf_valid_d = 1'b1;
    end else if (take) begin
      buf_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:   if (buf_valid_q) state_d = deg_in ? F_PUSH : F_SHIFT;
      F_SHIFT:  if (done_l && done_u) state_d = F_SQ;
      F_SQ:     state_d = F_SUM;
      F_SUM:    state_d = F_SQRT;
      F_SQRT:   if (bit_q[0]) state_d = F_DIVSET;
      F_DIVSET: state_d = F_DIV;
      F_DIV:    if (cnt_q == 5'(DIV_STEPS - 1)) state_d = F_PROD;
      F_PROD:   state_d = F_BASIS;
      F_BASIS:  state_d = F_WS;
      F_WS:     state_d = F_RING;
      F_RING: begin
        if (ph_q == 2'd2 && ring_q == 3'(RING_SIDES - 1)) state_d = F_PUSH;
      end
      F_PUSH:   if (!q_full_i) state_d = F_IDLE;
      default:  state_d = F_IDLE;
    endcase
  end

  // Step terms of the square root and divider lanes.
  always_comb begin
    for (int u = 0; u < 2; u++) begin
      sq_trial[u] = res_q[u] + bit_q;
      sq_ge[u]    = rad_q[u] >= sq_trial[u];
    end
    for (int k = 0; k < 5; k++) begin
      div_len[k] = (k < 3) ? res_q[0][31:0] : res_q[1][31:0];
      div_t[k]   = {rem_q[k], nlo_q[k][30]};
      div_ge[k]  = div_t[k] >= {1'b0, div_len[k]};
    end
  end

  // Signed unit vectors: L from lanes 0..2, U from lanes 3..4.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lv_c[j] = v_q[j][31] ? -$signed({1'b0, quo_q[j]}) : $signed({1'b0, quo_q[j]});
    end
    u_c[0] = v_q[2][31] ? -$signed({1'b0, quo_q[3]}) : $signed({1'b0, quo_q[3]});
    u_c[1] = '0;
    u_c[2] = ($signed(v_q[0]) > 32'sd0) ? -$signed({1'b0, quo_q[4]})
                                        : $signed({1'b0, quo_q[4]});
  end

  // Ring direction before rounding, apex and ring vertices.
  always_comb begin
    u64    = '0;
    apq    = '0;
    apex64 = '0;
    tr64   = '0;
    hr64   = '0;
    p64    = '0;
    ltl64  = '0;
    for (int j = 0; j < 3; j++) begin
      u64 = 64'(u_c[j]);
      unique case (ring_q)
        3'd0:    ring_sum[j] = u64 <<< 30;
        3'd1:    ring_sum[j] = (u64 <<< 29) + ws_q[j];
        3'd2:    ring_sum[j] = -(u64 <<< 29) + ws_q[j];
        3'd3:    ring_sum[j] = -(u64 <<< 30);
        3'd4:    ring_sum[j] = -(u64 <<< 29) - ws_q[j];
        3'd5:    ring_sum[j] = (u64 <<< 29) - ws_q[j];
        default: ring_sum[j] = '0;
      endcase
      p64       = 64'($signed(p_q[j]));
      apq       = (app_q[j] + 64'd32768) >> 16;
      apex64    = v_q[j][31] ? p64 - $signed(apq) : p64 + $signed(apq);
      apex_c[j] = sat32(apex64);
      tr64      = rnd30(trp_q[j]);
      hr64      = rnd30(hrp_q[j]);
      ltl64     = 64'(ltl_q[j]);
      vb_c[j]   = sat32(p64 + tr64);
      vm_c[j]   = sat32(p64 + tr64 + ltl64);
      vh_c[j]   = sat32(p64 + hr64 + ltl64);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      buf_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      buf_valid_q <= buf_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !buf_valid_q) begin
      buf_q <= in_item_i;
    end
    unique case (state_q)
      F_IDLE: begin
        if (buf_valid_q) begin
          p_q      <= {buf_q.point_z, buf_q.point_y, buf_q.point_x};
          v_q      <= {buf_q.vector_z, buf_q.vector_y, buf_q.vector_x};
          mag_q[0] <= abs32(buf_q.vector_x);
          mag_q[1] <= abs32(buf_q.vector_y);
          mag_q[2] <= abs32(buf_q.vector_z);
          mag_q[3] <= abs32(buf_q.vector_z);
          mag_q[4] <= abs32(buf_q.vector_x);
          for (int k = 0; k < VTX_COUNT; k++) begin
            vset_q.vtx[k] <= {buf_q.point_z, buf_q.point_y, buf_q.point_x};
          end
          vset_q.deg <= deg_in;
        end
      end
      F_SHIFT: begin
        for (int k = 0; k < 5; k++) begin
          if ((k < 3) ? !done_l : !done_u) begin
            mag_q[k] <= mag_q[k] << 1;
          end
        end
      end
      F_SQ: begin
        for (int k = 0; k < 5; k++) begin
          sq_q[k] <= mag_q[k] * mag_q[k];
        end
      end
      F_SUM: begin
        rad_q[0] <= sq_q[0] + sq_q[1] + sq_q[2];
        rad_q[1] <= sq_q[3] + sq_q[4];
        res_q[0] <= '0;
        res_q[1] <= '0;
        bit_q    <= 64'd1 << 62;
      end
      F_SQRT: begin
        for (int u = 0; u < 2; u++) begin
          if (sq_ge[u]) begin
            rad_q[u] <= rad_q[u] - sq_trial[u];
            res_q[u] <= (res_q[u] >> 1) + bit_q;
          end else begin
            res_q[u] <= res_q[u] >> 1;
          end
        end
        bit_q <= bit_q >> 2;
      end
      F_DIVSET: begin
        for (int k = 0; k < 5; k++) begin
          rem_q[k] <= 32'(({mag_q[k], 30'b0} + 62'(div_len[k] >> 1)) >> 31);
          nlo_q[k] <= 31'({mag_q[k], 30'b0} + 62'(div_len[k] >> 1));
        end
        cnt_q <= '0;
      end
      F_DIV: begin
        for (int k = 0; k < 5; k++) begin
          if (div_ge[k]) begin
            rem_q[k] <= 32'(div_t[k] - {1'b0, div_len[k]});
          end else begin
            rem_q[k] <= div_t[k][31:0];
          end
          quo_q[k] <= {quo_q[k][29:0], div_ge[k]};
          nlo_q[k] <= nlo_q[k] << 1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
      F_PROD: begin
        pw_q[0] <= u_c[2] * lv_c[1];
        pw_q[1] <= u_c[2] * lv_c[0];
        pw_q[2] <= u_c[0] * lv_c[2];
        pw_q[3] <= u_c[0] * lv_c[1];
        for (int j = 0; j < 3; j++) begin
          ltp_q[j] <= lv_c[j] * $signed({1'b0, cfg_i.tail_length});
          app_q[j] <= abs32(v_q[j]) * span;
        end
      end
      F_BASIS: begin
        w_q[0] <= 34'(rnd30(-pw_q[0]));
        w_q[1] <= 34'(rnd30(pw_q[1] - pw_q[2]));
        w_q[2] <= 34'(rnd30(pw_q[3]));
        for (int j = 0; j < 3; j++) begin
          ltl_q[j] <= 34'(rnd30(ltp_q[j]));
        end
        vset_q.vtx[APEX_IDX] <= apex_c;
      end
      F_WS: begin
        for (int j = 0; j < 3; j++) begin
          ws_q[j] <= w_q[j] * $signed({1'b0, SIN60});
        end
        ring_q <= '0;
        ph_q   <= '0;
      end
      F_RING: begin
        unique case (ph_q)
          2'd0: begin
            for (int j = 0; j < 3; j++) begin
              d_q[j] <= 34'(rnd30(ring_sum[j]));
            end
            ph_q <= 2'd1;
          end
          2'd1: begin
            for (int j = 0; j < 3; j++) begin
              trp_q[j] <= d_q[j] * $signed({1'b0, cfg_i.tail_radius});
              hrp_q[j] <= d_q[j] * $signed({1'b0, cfg_i.head_radius});
            end
            ph_q <= 2'd2;
          end
          default: begin
            vset_q.vtx[VB_BASE + VTX_W'(ring_q)] <= vb_c;
            vset_q.vtx[VM_BASE + VTX_W'(ring_q)] <= vm_c;
            vset_q.vtx[VH_BASE + VTX_W'(ring_q)] <= vh_c;
            ring_q <= ring_q + 3'd1;
            ph_q   <= 2'd0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // While dividing, every partial remainder stays below its divisor.
  a_div_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_DIV) |-> ((rem_q[0] < div_len[0]) && (rem_q[1] < div_len[1]) &&
                           (rem_q[2] < div_len[2]) && (rem_q[3] < div_len[3]) &&
                           (rem_q[4] < div_len[4])))
    else $error("divider remainder not below divisor");

endmodule

// ----- rtl/core/agtg_queue.sv -----
module agtg_queue import agtg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  vset_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output vset_t head_o
);

  vset_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("glyph pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("glyph popped from an empty queue");

endmodule

// ----- rtl/core/agtg_emit.sv -----
module agtg_emit import agtg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vset_t     head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [TRI_W-1:0] k_q, k_d;
  logic             ov_q, ov_d;
  out_item_t        out_q, out_d;
  logic             load, fire, last;
  tri_sel_t         sel;
  vec3_t            va, vb, vc;

  assign load = !ov_q || !out_stall_i;
  assign fire = load && !empty_i;
  assign last = (k_q == TRI_W'(TRI_COUNT - 1));
  assign pop_o = fire && last;

  assign sel = tri_select(k_q);
  assign va  = head_i.vtx[sel.a];
  assign vb  = head_i.vtx[sel.b];
  assign vc  = head_i.vtx[sel.c];

  always_comb begin
    out_d.corner_a_x    = va[0];
    out_d.corner_a_y    = va[1];
    out_d.corner_a_z    = va[2];
    out_d.corner_b_x    = vb[0];
    out_d.corner_b_y    = vb[1];
    out_d.corner_b_z    = vb[2];
    out_d.corner_c_x    = vc[0];
    out_d.corner_c_y    = vc[1];
    out_d.corner_c_z    = vc[2];
    out_d.last_triangle = last;
    out_d.degenerate    = head_i.deg;
    k_d  = k_q;
    ov_d = ov_q;
    if (fire) begin
      k_d  = last ? '0 : k_q + TRI_W'(1);
      ov_d = 1'b1;
    end else if (load) begin
      ov_d = 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      k_q  <= k_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  // A glyph that is partly sent must still sit at the queue head.
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != '0) |-> !empty_i)
    else $error("glyph left the queue before all triangles were sent");

  a_restart_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (k_q == '0) && out_valid_o && out_item_o.last_triangle)
    else $error("triangle counter did not restart after the last triangle");

endmodule

// ----- rtl/core/arrow_glyph_triangle_generator.sv -----
// Channel  Direction  Handshake                        Payload
// in       input      in_valid_i / in_stall_o          in_item_i (point and vector)
// out      output     out_valid_o / out_stall_i        out_item_o (one triangle)
// cfg      input      psel, penable, pwrite / pready   paddr, pwdata, prdata
//
// Each glyph gives 30 triangles, one per cycle while the output is not stalled.
// The front works through shifting, square root, dividing, ring and single steps
// for each glyph, so it sets the intake rate; a degenerate vector goes straight to
// the push. Reset sets the four registers to their defaults.
// A two-glyph queue lets the front keep working while the output is stalled.
module arrow_glyph_triangle_generator import agtg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_we;
  logic     push, full, pop, empty;
  vset_t    push_data, head;

  // The register bank never holds off an access: pready is always high.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_TAIL_LENGTH: prdata = {1'b0, cfg_q.tail_length};
      REG_HEAD_LENGTH: prdata = {1'b0, cfg_q.head_length};
      REG_TAIL_RADIUS: prdata = {1'b0, cfg_q.tail_radius};
      REG_HEAD_RADIUS: prdata = {1'b0, cfg_q.head_radius};
      default:         prdata = '0;
    endcase
  end

  // Each register keeps the low 31 bits of the written word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tail_length <= TAIL_LENGTH_RST;
      cfg_q.head_length <= HEAD_LENGTH_RST;
      cfg_q.tail_radius <= TAIL_RADIUS_RST;
      cfg_q.head_radius <= HEAD_RADIUS_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_TAIL_LENGTH: cfg_q.tail_length <= pwdata[30:0];
        REG_HEAD_LENGTH: cfg_q.head_length <= pwdata[30:0];
        REG_TAIL_RADIUS: cfg_q.tail_radius <= pwdata[30:0];
        REG_HEAD_RADIUS: cfg_q.head_radius <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // The front normalizes the vector, builds the ring basis and computes all
  // nineteen vertices of a glyph, which it hands over as one queue entry.
  agtg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .push_o      (push),
    .push_data_o (push_data),
    .q_full_i    (full)
  );

  agtg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // The emitter walks the fixed triangle order over the head entry and
  // releases the entry with the last triangle.
  agtg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
